/* hw/rtl/encoder_speed_pi_controller_core_defines.svh */
// Assertion macros used by the checker file of the speed controller.
`ifndef ENCODER_SPEED_PI_CONTROLLER_CORE_DEFINES_SVH
`define ENCODER_SPEED_PI_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define ESPI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("speed controller assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define ESPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("speed controller assertion failed");

`endif

/* hw/rtl/espi_pkg.sv */
// Package with the types, constants and helper functions of the speed controller.
`default_nettype none
package espi_pkg;

    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KP          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_HALF_T   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 3'd6;

    localparam logic [30:0] SPEED_SCALE_RESET = 31'd65536;

    localparam logic [1:0] DIR_HALT = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    typedef struct packed {
        logic        [15:0] count;
        logic signed [31:0] setpoint;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] speed;
        logic signed [15:0] delta;
        logic        [1:0]  direction;
    } t_out_item;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPEED,
        S_ERROR,
        S_PROP,
        S_INC,
        S_INTEG,
        S_DRIVE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SPEED,
        OP_ERROR,
        OP_PROP,
        OP_INC,
        OP_INTEG,
        OP_DRIVE
    } t_dp_op;

    typedef struct packed {
        logic   load_in;
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if ((&v[64:31]) || !(|v[64:31])) begin
            r = v[31:0];
        end else if (v[64]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [32:0] v,
                                                   input logic signed [31:0] hi,
                                                   input logic signed [31:0] lo);
        logic signed [31:0] r;
        if (v > 33'(hi)) begin
            r = hi;
        end else if (v < 33'(lo)) begin
            r = lo;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/encoder_speed_pi_controller_core.sv */
// Top level of the encoder speed PI controller: controller and datapath.
//
//  Channel   Direction  Handshake             Payload
//  in        input      i_in_valid/o_in_stall  t_in_item (count, setpoint)
//  out       output     o_out_valid/i_out_stall t_out_item (drive, speed, delta, direction)
//  cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// An input runs through S_SPEED, S_ERROR, S_PROP, S_INC, S_INTEG and S_DRIVE, which
// registers the result; the next input is taken in S_IDLE, and three of the six datapath steps
// share one 33 by 32 bit multiplier. Reset is synchronous and returns the state to zero.
// A stalled result holds the last step, and the input stays stalled while a tick is in work.
// Configuration writes are taken in every cycle.
`default_nettype none
module encoder_speed_pi_controller_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire espi_pkg::t_in_item                   i_in_data,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output espi_pkg::t_out_item                       o_out_data,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [espi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [31:0]                          i_cfg_data
);
    import espi_pkg::*;

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_cfg_wr w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    espi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    espi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* hw/rtl/espi_ctrl.sv */
// Controller state machine that sequences the datapath steps of one control tick.
`default_nettype none
module espi_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire espi_pkg::t_stat i_stat,
    output espi_pkg::t_cmd      o_cmd
);
    import espi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.load_in = 1'b0;
        o_cmd.op      = OP_NONE;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SPEED;
                end
            end
            S_SPEED: begin
                o_cmd.op = OP_SPEED;
                n_state  = S_ERROR;
            end
            S_ERROR: begin
                o_cmd.op = OP_ERROR;
                n_state  = S_PROP;
            end
            S_PROP: begin
                o_cmd.op = OP_PROP;
                n_state  = S_INC;
            end
            S_INC: begin
                o_cmd.op = OP_INC;
                n_state  = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = S_DRIVE;
            end
            S_DRIVE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_DRIVE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/espi_dp.sv */
// Datapath with configuration registers, controller state, shared multiplier and result register.
`default_nettype none
module espi_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire espi_pkg::t_cfg_wr  i_cfg,
    input  wire espi_pkg::t_in_item i_in_data,
    input  wire espi_pkg::t_cmd     i_cmd,
    output espi_pkg::t_stat         o_stat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output espi_pkg::t_out_item     o_out_data
);
    import espi_pkg::*;

    logic        [30:0] r_kp;
    logic        [30:0] r_ki_half_t;
    logic signed [31:0] r_integ_max;
    logic signed [31:0] r_integ_min;
    logic signed [31:0] r_out_max;
    logic signed [31:0] r_out_min;
    logic        [30:0] r_speed_scale;

    logic [COUNT_BITS-1:0] r_last_count;
    logic signed [31:0]    r_integ;
    logic signed [31:0]    r_last_error;

    t_in_item           r_in;
    logic signed [64:0] r_prod;
    logic signed [31:0] r_speed;
    logic signed [31:0] r_error;
    logic signed [31:0] r_prop;
    logic signed [15:0] r_delta;
    logic        [1:0]  r_dir;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [COUNT_BITS-1:0]    w_cnt;
    logic signed [COUNT_BITS-1:0] w_delta;
    logic signed [32:0]       w_delta_x;
    logic signed [15:0]       w_delta16;
    logic signed [31:0]       w_speed;
    logic signed [32:0]       w_diff;
    logic signed [32:0]       w_err_sum;
    logic signed [31:0]       w_inc;
    logic signed [31:0]       w_integ;
    logic signed [32:0]       w_mul_a;
    logic signed [31:0]       w_mul_b;

    assign w_cnt     = COUNT_BITS'(r_in.count);
    assign w_delta   = signed'(w_cnt - r_last_count);
    assign w_delta_x = 33'(w_delta);
    assign w_delta16 = ((&w_delta_x[32:15]) || !(|w_delta_x[32:15])) ? w_delta_x[15:0] :
                       (w_delta_x[32] ? 16'sh8000 : 16'sh7FFF);
    assign w_speed   = sat32(r_prod);
    assign w_diff    = 33'(r_in.setpoint) - 33'(w_speed);
    assign w_err_sum = 33'(r_error) + 33'(r_last_error);
    assign w_inc     = sat32(r_prod >>> FRAC_BITS);
    assign w_integ   = clamp32(33'(r_integ) + 33'(w_inc), r_integ_max, r_integ_min);

    always_comb begin
        case (i_cmd.op)
            OP_SPEED: begin
                w_mul_a = w_delta_x;
                w_mul_b = signed'({1'b0, r_speed_scale});
            end
            OP_PROP: begin
                w_mul_a = 33'(r_error);
                w_mul_b = signed'({1'b0, r_kp});
            end
            OP_INC: begin
                w_mul_a = w_err_sum;
                w_mul_b = signed'({1'b0, r_ki_half_t});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= '0;
            r_ki_half_t   <= '0;
            r_integ_max   <= '0;
            r_integ_min   <= '0;
            r_out_max     <= '0;
            r_out_min     <= '0;
            r_speed_scale <= SPEED_SCALE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KP:          r_kp          <= i_cfg.data[30:0];
                CFG_KI_HALF_T:   r_ki_half_t   <= i_cfg.data[30:0];
                CFG_INTEG_MAX:   r_integ_max   <= signed'(i_cfg.data);
                CFG_INTEG_MIN:   r_integ_min   <= signed'(i_cfg.data);
                CFG_OUT_MAX:     r_out_max     <= signed'(i_cfg.data);
                CFG_OUT_MIN:     r_out_min     <= signed'(i_cfg.data);
                CFG_SPEED_SCALE: r_speed_scale <= i_cfg.data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
            r_integ      <= '0;
            r_last_error <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_SPEED) begin
                r_last_count <= w_cnt;
            end
            if (i_cmd.op == OP_INTEG) begin
                r_integ      <= w_integ;
                r_last_error <= r_error;
            end
            if (i_cmd.op == OP_DRIVE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.op == OP_SPEED || i_cmd.op == OP_PROP || i_cmd.op == OP_INC) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_cmd.op == OP_SPEED) begin
            r_delta <= w_delta16;
            if (w_delta == '0) begin
                r_dir <= DIR_HALT;
            end else if (w_delta[COUNT_BITS-1]) begin
                r_dir <= DIR_REV;
            end else begin
                r_dir <= DIR_FWD;
            end
        end
        if (i_cmd.op == OP_ERROR) begin
            r_speed <= w_speed;
            r_error <= sat32(65'(w_diff));
        end
        if (i_cmd.op == OP_INC) begin
            r_prop <= sat32(r_prod >>> FRAC_BITS);
        end
        if (i_cmd.op == OP_DRIVE) begin
            r_out.drive     <= clamp32(33'(r_prop) + 33'(r_integ), r_out_max, r_out_min);
            r_out.speed     <= r_speed;
            r_out.delta     <= r_delta;
            r_out.direction <= r_dir;
        end
    end

    assign o_stat.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule
`default_nettype wire

/* hw/rtl/espi_chk.sv */
// Port checker for the speed controller, bound to the top level.
`default_nettype none
`include "encoder_speed_pi_controller_core_defines.svh"
module espi_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire espi_pkg::t_out_item            o_out_data
);
    import espi_pkg::*;

    `ESPI_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `ESPI_ASSERT_NEXT(a_out_held, o_out_valid && i_out_stall, o_out_valid)
    `ESPI_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))
    `ESPI_ASSERT_IMPL(a_dir_code, o_out_valid,
        o_out_data.direction == DIR_HALT || o_out_data.direction == DIR_FWD ||
        o_out_data.direction == DIR_REV)
    `ESPI_ASSERT_IMPL(a_stop_speed, o_out_valid && o_out_data.direction == DIR_HALT,
        o_out_data.speed == 32'sd0 && o_out_data.delta == 16'sd0)

endmodule

bind encoder_speed_pi_controller_core espi_chk u_espi_chk (.*);
`default_nettype wire
